// File: src/gbn_pkg.sv
// shared types and constants for the go-back-n sender
// used by gbn_ctrl, gbn_dp and go_back_n_sender; depends on nothing
package gbn_pkg;

  // sequence space and field widths
  localparam int SEQ_SPACE = 16;
  localparam int SEQ_BITS  = 4;
  localparam int TAG_BITS  = 32;
  localparam int WIN_BITS  = 4;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = 4'd7;

  // command codes of an input word; code 3 is ignored
  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic take_in;    // capture the input word into the hold register
    logic exec_hold;  // run the held word and load its single result
    logic start_rtx;  // point the retransmit index at the window base
    logic emit_rtx;   // load one retransmission and step the index
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic hold_rtx;   // held word is a timeout with packets outstanding
    logic rtx_final;  // current retransmit slot is the newest outstanding one
  } dp_status_t;

endpackage

// File: src/gbn_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/gbn_ctrl.sv
// sequencing controller for the go-back-n sender
// depends on gbn_pkg; drives the datapath through gbn_pkg::ctrl_cmd_t
module gbn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbn_pkg::dp_status_t status,
  output gbn_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HOLD,
    S_RTX_LOAD,
    S_RTX_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_take;

  // next state and command decode
  always_comb begin
    state_next = state;
    can_take   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        can_take = 1'b1;
      end
      S_HOLD: begin
        if (status.out_free) begin
          if (status.hold_rtx) begin
            cmd.start_rtx = 1'b1;
            state_next    = S_RTX_LOAD;
          end else begin
            cmd.exec_hold = 1'b1;
            can_take      = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      S_RTX_LOAD: begin
        state_next = S_RTX_EMIT;
      end
      S_RTX_EMIT: begin
        if (status.out_free) begin
          cmd.emit_rtx = 1'b1;
          if (status.rtx_final) begin
            can_take   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // a word taken now is held for the next cycle
    cmd.take_in = can_take && in_valid;
    if (cmd.take_in) begin
      state_next = S_HOLD;
    end
  end

  assign in_stall = !can_take;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/gbn_dp.sv
// datapath of the go-back-n sender: window pointers, slot store, hold and output words
// depends on gbn_pkg and gbn_ram; steered by gbn_ctrl
module gbn_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  gbn_pkg::ctrl_cmd_t            cmd,
  output gbn_pkg::dp_status_t           status,
  // input word
  input  logic [1:0]                    command,
  input  logic [gbn_pkg::TAG_BITS-1:0]  msg_tag,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  ack_seq,
  input  logic                          ack_good,
  // result word
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          xmit_valid,
  output logic [gbn_pkg::SEQ_BITS-1:0]  xmit_seq,
  output logic [gbn_pkg::TAG_BITS-1:0]  xmit_tag,
  output logic                          accepted,
  output logic                          timer_start,
  output logic                          timer_stop,
  output logic                          last,
  // window size register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbn_pkg::WIN_BITS-1:0]  window_size
);

  // hold register for one input word
  gbn_pkg::cmd_t                 hold_cmd;
  logic [gbn_pkg::TAG_BITS-1:0]  hold_tag;
  logic [gbn_pkg::SEQ_BITS-1:0]  hold_ack;
  logic                          hold_good;

  // window state
  logic [gbn_pkg::WIN_BITS-1:0]  win_size;
  logic [gbn_pkg::SEQ_BITS-1:0]  window_base;
  logic [gbn_pkg::SEQ_BITS-1:0]  window_base_next;
  logic [gbn_pkg::SEQ_BITS-1:0]  next_seq;
  logic [gbn_pkg::SEQ_BITS-1:0]  next_seq_next;

  // retransmit walk
  logic [gbn_pkg::SEQ_BITS-1:0]  idx;
  logic [gbn_pkg::SEQ_BITS-1:0]  idx_next;
  logic [gbn_pkg::SEQ_BITS-1:0]  idx_inc;
  logic [gbn_pkg::TAG_BITS-1:0]  slot_rdata;

  // derived window quantities
  logic [gbn_pkg::SEQ_BITS-1:0]  outstanding;
  logic [gbn_pkg::SEQ_BITS-1:0]  ack_dist;
  logic [gbn_pkg::SEQ_BITS-1:0]  ack_inc;
  logic                          send_ok;
  logic                          ack_ok;
  logic                          slot_we;

  // result word being formed
  logic                          res_xvalid;
  logic [gbn_pkg::SEQ_BITS-1:0]  res_seq;
  logic [gbn_pkg::TAG_BITS-1:0]  res_tag;
  logic                          res_acc;
  logic                          res_tstart;
  logic                          res_tstop;
  logic                          res_last;
  logic                          out_load;

  // modulo arithmetic wraps naturally in the sequence width
  assign outstanding = next_seq - window_base;
  assign ack_dist    = hold_ack - window_base;
  assign ack_inc     = hold_ack + 1'b1;
  assign idx_inc     = idx + 1'b1;
  // window size is at most SEQ_SPACE-1 by its width, so no clamp is needed
  assign send_ok     = outstanding < win_size;
  assign ack_ok      = hold_good && (ack_dist < outstanding);
  assign slot_we     = cmd.exec_hold && (hold_cmd == gbn_pkg::CMD_SEND) && send_ok;

  // status toward the controller
  assign status.out_free  = !out_valid || !out_stall;
  assign status.hold_rtx  = (hold_cmd == gbn_pkg::CMD_TIMEOUT) && (outstanding != '0);
  assign status.rtx_final = idx_inc == next_seq;

  // result word and pointer updates
  always_comb begin
    res_xvalid       = 1'b0;
    res_seq          = '0;
    res_tag          = '0;
    res_acc          = 1'b0;
    res_tstart       = 1'b0;
    res_tstop        = 1'b0;
    res_last         = 1'b1;
    window_base_next = window_base;
    next_seq_next    = next_seq;
    idx_next         = idx;
    if (cmd.emit_rtx) begin
      res_xvalid = 1'b1;
      res_seq    = idx;
      res_tag    = slot_rdata;
      res_tstart = idx == window_base;
      res_last   = status.rtx_final;
      idx_next   = idx_inc;
    end else if (cmd.start_rtx) begin
      idx_next = window_base;
    end else if (cmd.exec_hold) begin
      case (hold_cmd)
        gbn_pkg::CMD_SEND: begin
          if (send_ok) begin
            res_xvalid    = 1'b1;
            res_seq       = next_seq;
            res_tag       = hold_tag;
            res_acc       = 1'b1;
            res_tstart    = outstanding == '0;
            next_seq_next = next_seq + 1'b1;
          end
        end
        gbn_pkg::CMD_ACK: begin
          if (ack_ok) begin
            window_base_next = ack_inc;
            res_tstart       = ack_inc != next_seq;
            res_tstop        = 1'b1;
          end
        end
        gbn_pkg::CMD_TIMEOUT: begin
          // only reached with nothing outstanding
          res_tstart = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_load = cmd.exec_hold || cmd.emit_rtx;

  // slot descriptor store; read address follows the walk index
  gbn_ram #(
    .WIDTH (gbn_pkg::TAG_BITS),
    .DEPTH (gbn_pkg::SEQ_SPACE)
  ) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (next_seq),
    .wdata (hold_tag),
    .raddr (idx_next),
    .rdata (slot_rdata)
  );

  // configuration write port, always ready
  assign cfg_ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_size    <= gbn_pkg::WINDOW_RESET;
      window_base <= '0;
      next_seq    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        win_size <= window_size;
      end
      window_base <= window_base_next;
      next_seq    <= next_seq_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.take_in) begin
      hold_cmd  <= gbn_pkg::cmd_t'(command);
      hold_tag  <= msg_tag;
      hold_ack  <= ack_seq;
      hold_good <= ack_good;
    end
    if (out_load) begin
      xmit_valid  <= res_xvalid;
      xmit_seq    <= res_seq;
      xmit_tag    <= res_tag;
      accepted    <= res_acc;
      timer_start <= res_tstart;
      timer_stop  <= res_tstop;
      last        <= res_last;
    end
  end

endmodule

// File: src/go_back_n_sender.sv
// go-back-n sender: send and ack words give one result; a word is taken every cycle
// when the output is free and no walk runs; a taken word is held, then its result loaded
// timeout with n outstanding: point the walk index and start the slot store read, then
// n results one per cycle unless stalled; the next word is taken with the final result
// synchronous active-high reset: window base and next sequence zero, window size 7,
// output empty; slot store contents undefined until written (no clearing pass)
module go_back_n_sender (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [gbn_pkg::TAG_BITS-1:0]  msg_tag,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  ack_seq,
  input  logic                          ack_good,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          xmit_valid,
  output logic [gbn_pkg::SEQ_BITS-1:0]  xmit_seq,
  output logic [gbn_pkg::TAG_BITS-1:0]  xmit_tag,
  output logic                          accepted,
  output logic                          timer_start,
  output logic                          timer_stop,
  output logic                          last,
  // window size write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbn_pkg::WIN_BITS-1:0]  window_size
);

  gbn_pkg::ctrl_cmd_t  cmd;
  gbn_pkg::dp_status_t status;

  // sequencing
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // window state, slot store and output word
  gbn_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .command     (command),
    .msg_tag     (msg_tag),
    .ack_seq     (ack_seq),
    .ack_good    (ack_good),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .xmit_valid  (xmit_valid),
    .xmit_seq    (xmit_seq),
    .xmit_tag    (xmit_tag),
    .accepted    (accepted),
    .timer_start (timer_start),
    .timer_stop  (timer_stop),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .window_size (window_size)
  );

endmodule

// File: dv/testbench.sv
// testbench for go_back_n_sender: a scoreboard class predicts every result word,
// plain tasks drive send, ack and timeout words with random gaps and output stalls
// depends on gbn_pkg and go_back_n_sender
module testbench;

  localparam int CYCLE = 12;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SEQ_SPACE = gbn_pkg::SEQ_SPACE;
  localparam int SEQ_BITS  = gbn_pkg::SEQ_BITS;
  localparam int TAG_BITS  = gbn_pkg::TAG_BITS;
  localparam int WIN_BITS  = gbn_pkg::WIN_BITS;
  localparam logic [WIN_BITS-1:0] WINDOW_RESET = gbn_pkg::WINDOW_RESET;
  // command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           command;
  logic [TAG_BITS-1:0]  msg_tag;
  logic [SEQ_BITS-1:0]  ack_seq;
  logic                 ack_good;
  logic                 out_valid;
  logic                 out_stall;
  logic                 xmit_valid;
  logic [SEQ_BITS-1:0]  xmit_seq;
  logic [TAG_BITS-1:0]  xmit_tag;
  logic                 accepted;
  logic                 timer_start;
  logic                 timer_stop;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [WIN_BITS-1:0]  window_size;

  // one result word
  typedef struct packed {
    logic                xmit_valid;
    logic [SEQ_BITS-1:0] seq;
    logic [TAG_BITS-1:0] tag;
    logic                acc;
    logic                t_start;
    logic                t_stop;
    logic                is_last;
  } xmit_word_t;

  // window tracker: mirrors base, next sequence and slot tags, queues expected words
  class sender_scoreboard;
    logic [WIN_BITS-1:0] win_size;
    logic [SEQ_BITS-1:0] base;
    logic [SEQ_BITS-1:0] next_seq;
    logic [TAG_BITS-1:0] slot_tag [SEQ_SPACE];
    xmit_word_t          due_words[$];
    int                  errors;

    function new();
      win_size = WINDOW_RESET;
      base     = '0;
      next_seq = '0;
      errors   = 0;
    endfunction

    function int in_flight();
      logic [SEQ_BITS-1:0] d;
      d = next_seq - base;
      return int'(d);
    endfunction

    function void queue_word(logic xv, logic [SEQ_BITS-1:0] seq, logic [TAG_BITS-1:0] tag,
                             logic acc, logic t_start, logic t_stop, logic is_last);
      xmit_word_t w;
      w.xmit_valid = xv;
      w.seq        = seq;
      w.tag        = tag;
      w.acc        = acc;
      w.t_start    = t_start;
      w.t_stop     = t_stop;
      w.is_last    = is_last;
      due_words.push_back(w);
    endfunction

    // accepted input word: update the window and queue its result words
    function void take_word(logic [1:0] cmd, logic [TAG_BITS-1:0] tag,
                            logic [SEQ_BITS-1:0] ack, logic good);
      int n;
      logic [SEQ_BITS-1:0] ack_off;
      logic [SEQ_BITS-1:0] idx;
      n       = in_flight();
      ack_off = ack - base;
      case (cmd)
        gbn_pkg::CMD_SEND: begin
          // a 4-bit window never exceeds the sequence space less one
          if (n < int'(win_size)) begin
            slot_tag[next_seq] = tag;
            queue_word(1'b1, next_seq, tag, 1'b1, n == 0, 1'b0, 1'b1);
            next_seq = next_seq + 1'b1;
          end else begin
            queue_word(1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
          end
        end
        gbn_pkg::CMD_ACK: begin
          // only a good ack of an outstanding packet slides the base
          if (good && int'(ack_off) < n) begin
            base = ack + 1'b1;
            queue_word(1'b0, '0, '0, 1'b0, base != next_seq, 1'b1, 1'b1);
          end else begin
            queue_word(1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
          end
        end
        gbn_pkg::CMD_TIMEOUT: begin
          if (n == 0) begin
            queue_word(1'b0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b1);
          end else begin
            idx = base;
            for (int k = 0; k < n; k++) begin
              queue_word(1'b1, idx, slot_tag[idx], 1'b0, k == 0, 1'b0, k == n - 1);
              idx = idx + 1'b1;
            end
          end
        end
        default: queue_word(1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
      endcase
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // accepted result word against the oldest expectation
    function void match_result(xmit_word_t got);
      xmit_word_t want;
      if (due_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = due_words.pop_front();
      check_field("xmit_valid", want.xmit_valid, got.xmit_valid);
      check_field("xmit_seq", want.seq, got.seq);
      check_field("xmit_tag", want.tag, got.tag);
      check_field("accepted", want.acc, got.acc);
      check_field("timer_start", want.t_start, got.t_start);
      check_field("timer_stop", want.t_stop, got.t_stop);
      check_field("last", want.is_last, got.is_last);
    endfunction
  endclass

  sender_scoreboard sb;
  int               send_calm;
  int               words_sent;

  go_back_n_sender DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .msg_tag     (msg_tag),
    .ack_seq     (ack_seq),
    .ack_good    (ack_good),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .xmit_valid  (xmit_valid),
    .xmit_seq    (xmit_seq),
    .xmit_tag    (xmit_tag),
    .accepted    (accepted),
    .timer_start (timer_start),
    .timer_stop  (timer_stop),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .window_size (window_size)
  );

  always #(CYCLE / 2) clk = ~clk;

  // gap length: mostly none, often short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // present one input word, wait for it to be taken, then maybe idle
  task automatic put_word(input logic [1:0] cmd, input logic [TAG_BITS-1:0] tag,
                          input logic [SEQ_BITS-1:0] seq, input logic good);
    int gap;
    in_valid <= 1'b1;
    command  <= cmd;
    msg_tag  <= tag;
    ack_seq  <= seq;
    ack_good <= good;
    do @(posedge clk); while (in_stall);
    sb.take_word(cmd, tag, seq, good);
    words_sent++;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off input until every expected word has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_BITS-1:0] size);
    cfg_valid   <= 1'b1;
    window_size <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.win_size = size;
  endtask

  // mostly well-formed traffic: sends, acks of outstanding packets, timeouts
  task automatic random_word();
    int r;
    int n;
    logic [TAG_BITS-1:0] tag;
    logic [SEQ_BITS-1:0] seq;
    logic good;
    n    = sb.in_flight();
    r    = $urandom_range(0, 99);
    tag  = $urandom();
    seq  = SEQ_BITS'($urandom_range(0, SEQ_SPACE - 1));
    good = 1'($urandom_range(0, 1));
    if (r < 45) begin
      put_word(gbn_pkg::CMD_SEND, tag, seq, good);
    end else if (r < 70 && n > 0) begin
      put_word(gbn_pkg::CMD_ACK, tag, sb.base + SEQ_BITS'($urandom_range(0, n - 1)), 1'b1);
    end else if (r < 82) begin
      put_word(gbn_pkg::CMD_TIMEOUT, tag, seq, good);
    end else if (r < 90) begin
      // ack with a random sequence number, often bad or stale
      put_word(gbn_pkg::CMD_ACK, tag, seq, good);
    end else if (r < 95) begin
      put_word(CMD_UNUSED, tag, seq, good);
    end else begin
      // fill the window, then let the timer expire
      while (sb.in_flight() < int'(sb.win_size))
        put_word(gbn_pkg::CMD_SEND, $urandom(), SEQ_BITS'($urandom_range(0, SEQ_SPACE - 1)),
                 1'($urandom_range(0, 1)));
      put_word(gbn_pkg::CMD_TIMEOUT, tag, seq, good);
    end
  endtask

  // result side: random stalls, check every accepted word
  initial begin
    int stall_left;
    int calm_left;
    xmit_word_t got;
    stall_left = 0;
    calm_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.xmit_valid = xmit_valid;
        got.seq        = xmit_seq;
        got.tag        = xmit_tag;
        got.acc        = accepted;
        got.t_start    = timer_start;
        got.t_stop     = timer_stop;
        got.is_last    = last;
        sb.match_result(got);
      end
      if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(20, 80);
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // main sequence
  initial begin
    int win_steps [7];
    int budget [7];
    int target;
    sb         = new();
    send_calm  = 0;
    words_sent = 0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    command     <= gbn_pkg::CMD_SEND;
    msg_tag     <= '0;
    ack_seq     <= '0;
    ack_good    <= 1'b0;
    cfg_valid   <= 1'b0;
    window_size <= WINDOW_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty window, fill to the reset size, refusal, retransmit, acks
    put_word(gbn_pkg::CMD_TIMEOUT, 32'h0, 4'd0, 1'b0);
    put_word(gbn_pkg::CMD_ACK, 32'h0, 4'd0, 1'b1);
    put_word(CMD_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b1);
    put_word(gbn_pkg::CMD_SEND, 32'h0000_0000, 4'd15, 1'b1);
    put_word(gbn_pkg::CMD_SEND, 32'hFFFF_FFFF, 4'd0, 1'b0);
    repeat (5) put_word(gbn_pkg::CMD_SEND, $urandom(),
                        SEQ_BITS'($urandom_range(0, SEQ_SPACE - 1)), 1'($urandom_range(0, 1)));
    put_word(gbn_pkg::CMD_SEND, 32'hFFFF_FFFF, 4'd15, 1'b1);
    put_word(gbn_pkg::CMD_TIMEOUT, 32'h0, 4'd0, 1'b0);
    put_word(gbn_pkg::CMD_ACK, 32'h0, 4'd1, 1'b0);
    put_word(gbn_pkg::CMD_ACK, 32'h0, 4'd15, 1'b1);
    put_word(gbn_pkg::CMD_ACK, 32'h0, 4'd2, 1'b1);
    put_word(gbn_pkg::CMD_TIMEOUT, 32'hFFFF_FFFF, 4'd15, 1'b1);
    put_word(gbn_pkg::CMD_ACK, 32'h0, 4'd6, 1'b1);
    settle();

    // random phases, each under its own window size
    win_steps = '{1, 15, 0, 4, 0, 8, 15};
    win_steps[4] = $urandom_range(1, 15);
    budget = '{50, 110, 20, 60, 80, 60, 50};
    for (int p = 0; p < 7; p++) begin
      write_window(WIN_BITS'(win_steps[p]));
      target = words_sent + budget[p];
      while (words_sent < target) random_word();
      settle();
    end

    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(CYCLE * LIMIT_CYCLES);
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: files.f
src/gbn_pkg.sv
src/gbn_ram.sv
src/gbn_ctrl.sv
src/gbn_dp.sv
src/go_back_n_sender.sv
dv/testbench.sv
